>>> src/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared widths, request and status codes, default sizes and the command
// bundle passed from the controller to the datapath of the sorted queue.
// ----------------------------------------------------------------------------
package sspq_pkg;

    // port field widths
    localparam int PRIO_W   = 8;
    localparam int PAY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // default sizes
    localparam int DEF_DEPTH        = 16;
    localparam int DEF_PRIO_BITS    = 8;
    localparam int DEF_PAYLOAD_BITS = 16;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming request beat
        logic commit;   // update the cells and load the result
    } t_cmd;

endpackage

>>> src/stable_sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_core
// Sorted priority queue with first-in first-out order among equal
// priorities, built as a controller and a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The controller takes each request beat; once the result register is free,
// every cell compares against the new priority in parallel, the cells from
// the insert point on (or the whole row on a pop) shift by one place, and the
// result beat is loaded. A result that waits downstream does not block: the
// next request is taken meanwhile, and it commits once the waiting result
// has gone. The result shows status, popped entry, head and occupancy after
// the request. Storage holds DEPTH entries and needs no clearing after reset.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_core #(
    parameter int DEPTH        = sspq_pkg::DEF_DEPTH,
    parameter int PRIO_BITS    = sspq_pkg::DEF_PRIO_BITS,
    parameter int PAYLOAD_BITS = sspq_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [sspq_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic [sspq_pkg::PAY_W-1:0]    i_payload,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sspq_pkg::STATUS_W-1:0] o_status,
    output logic [sspq_pkg::PAY_W-1:0]    o_popped_payload,
    output logic [sspq_pkg::PRIO_W-1:0]   o_popped_priority,
    output logic                          o_head_valid,
    output logic [sspq_pkg::PAY_W-1:0]    o_head_payload,
    output logic [sspq_pkg::OCC_W-1:0]    o_occupancy
);

    sspq_pkg::t_cmd w_cmd;

    // controller
    sspq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // datapath
    sspq_datapath #(
        .DEPTH        (DEPTH),
        .PRIO_BITS    (PRIO_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_req_type        (i_req_type),
        .i_priority_req    (i_priority_req),
        .i_payload         (i_payload),
        .o_status          (o_status),
        .o_popped_payload  (o_popped_payload),
        .o_popped_priority (o_popped_priority),
        .o_head_valid      (o_head_valid),
        .o_head_payload    (o_head_payload),
        .o_occupancy       (o_occupancy)
    );

    // capture and commit never coincide
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.capture && w_cmd.commit))
        else $error("capture and commit in the same cycle");

    // a commit always presents a result beat
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_out_valid)
        else $error("commit without result beat");

    // a commit never overwrites a result beat still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> !w_cmd.commit)
        else $error("result overwritten while stalled");

    // a pop from empty leaves the queue empty
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == sspq_pkg::ST_EMPTY) |-> !o_head_valid)
        else $error("empty status with a head entry");

    // a refused insert shows a full queue
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == sspq_pkg::ST_FULL) |-> o_head_valid)
        else $error("full status with no head entry");

endmodule

>>> src/sspq_ctrl.sv
// ----------------------------------------------------------------------------
// sspq_ctrl
// Controller: sequences request capture and commit, and owns the valid
// flag of the result register so a new request can be taken while the
// previous result waits downstream.
// ----------------------------------------------------------------------------
module sspq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sspq_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_out_free;

    // result register can take a new beat
    assign w_out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> src/sspq_datapath.sv
// ----------------------------------------------------------------------------
// sspq_datapath
// Datapath: request latch, a row of sorted cells with the head in cell 0,
// the entry count and the result register. All cells compare against the new
// priority at once; those from the insert point on (all on pop) shift by one.
// ----------------------------------------------------------------------------
module sspq_datapath #(
    parameter int DEPTH        = sspq_pkg::DEF_DEPTH,
    parameter int PRIO_BITS    = sspq_pkg::DEF_PRIO_BITS,
    parameter int PAYLOAD_BITS = sspq_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sspq_pkg::t_cmd                i_cmd,
    input  logic                          i_req_type,
    input  logic [sspq_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic [sspq_pkg::PAY_W-1:0]    i_payload,
    output logic [sspq_pkg::STATUS_W-1:0] o_status,
    output logic [sspq_pkg::PAY_W-1:0]    o_popped_payload,
    output logic [sspq_pkg::PRIO_W-1:0]   o_popped_priority,
    output logic                          o_head_valid,
    output logic [sspq_pkg::PAY_W-1:0]    o_head_payload,
    output logic [sspq_pkg::OCC_W-1:0]    o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // latched request
    logic                    r_req_type;
    logic [PRIO_BITS-1:0]    r_prio;
    logic [PAYLOAD_BITS-1:0] r_pay;

    // cells and count
    logic [PRIO_BITS-1:0]    r_slot_prio [DEPTH];
    logic [PAYLOAD_BITS-1:0] r_slot_pay  [DEPTH];
    logic [PRIO_BITS-1:0]    n_slot_prio [DEPTH];
    logic [PAYLOAD_BITS-1:0] n_slot_pay  [DEPTH];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;

    // result register
    logic [sspq_pkg::STATUS_W-1:0] r_status;
    logic [sspq_pkg::STATUS_W-1:0] n_status;
    logic [PAYLOAD_BITS-1:0]       r_pop_pay;
    logic [PAYLOAD_BITS-1:0]       n_pop_pay;
    logic [PRIO_BITS-1:0]          r_pop_prio;
    logic [PRIO_BITS-1:0]          n_pop_prio;

    logic             w_ge [DEPTH];
    logic             w_full;
    logic             w_empty;
    logic             w_do_ins;
    logic             w_do_pop;
    logic [31:0]      w_in_prio_ext;
    logic [31:0]      w_in_pay_ext;

    // keep only the stored bits of the request fields
    assign w_in_prio_ext = 32'(i_priority_req);
    assign w_in_pay_ext  = 32'(i_payload);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_prio     <= w_in_prio_ext[PRIO_BITS-1:0];
            r_pay      <= w_in_pay_ext[PAYLOAD_BITS-1:0];
        end
    end

    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_do_ins = (r_req_type == sspq_pkg::REQ_INSERT) && !w_full;
    assign w_do_pop = (r_req_type == sspq_pkg::REQ_POP) && !w_empty;

    // per cell: held entry that stays ahead of the new one
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ge[i] = (CNT_W'(i) < r_count) && (r_slot_prio[i] >= r_prio);
        end
    end

    // next cell contents
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_slot_prio[i] = r_slot_prio[i];
            n_slot_pay[i]  = r_slot_pay[i];
        end
        if (w_do_ins) begin
            if (!w_ge[0]) begin
                n_slot_prio[0] = r_prio;
                n_slot_pay[0]  = r_pay;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (!w_ge[i]) begin
                    if (w_ge[i-1]) begin
                        n_slot_prio[i] = r_prio;
                        n_slot_pay[i]  = r_pay;
                    end else begin
                        n_slot_prio[i] = r_slot_prio[i-1];
                        n_slot_pay[i]  = r_slot_pay[i-1];
                    end
                end
            end
        end else if (w_do_pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_slot_prio[i] = r_slot_prio[i+1];
                n_slot_pay[i]  = r_slot_pay[i+1];
            end
        end
    end

    // count and result
    always_comb begin
        n_count    = r_count;
        n_status   = sspq_pkg::ST_DONE;
        n_pop_pay  = '0;
        n_pop_prio = '0;
        if (r_req_type == sspq_pkg::REQ_INSERT) begin
            if (w_full) begin
                n_status = sspq_pkg::ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = sspq_pkg::ST_EMPTY;
            end else begin
                n_count    = r_count - 1'b1;
                n_pop_pay  = r_slot_pay[0];
                n_pop_prio = r_slot_prio[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_slot_prio[i] <= n_slot_prio[i];
                r_slot_pay[i]  <= n_slot_pay[i];
            end
            r_status   <= n_status;
            r_pop_pay  <= n_pop_pay;
            r_pop_prio <= n_pop_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    // result beat: head and count only change at the next commit
    logic [31:0] w_pop_pay_ext;
    logic [31:0] w_pop_prio_ext;
    logic [31:0] w_head_pay_ext;
    logic [31:0] w_count_ext;

    assign w_pop_pay_ext  = 32'(r_pop_pay);
    assign w_pop_prio_ext = 32'(r_pop_prio);
    assign w_head_pay_ext = w_empty ? 32'd0 : 32'(r_slot_pay[0]);
    assign w_count_ext    = 32'(r_count);

    assign o_status          = r_status;
    assign o_popped_payload  = w_pop_pay_ext[sspq_pkg::PAY_W-1:0];
    assign o_popped_priority = w_pop_prio_ext[sspq_pkg::PRIO_W-1:0];
    assign o_head_valid      = !w_empty;
    assign o_head_payload    = w_head_pay_ext[sspq_pkg::PAY_W-1:0];
    assign o_occupancy       = w_count_ext[sspq_pkg::OCC_W-1:0];

endmodule
